FILE: rtl/bmf_pkg.sv
`default_nettype none

package bmf_pkg;

	// Fixed field widths
	localparam int PIX_W      = 8;
	localparam int KSZ_W      = 3;
	localparam int DIM_W      = 11;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	// Default sizing of the storage
	localparam int MAX_KERNEL_DEF = 7;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_KERNEL = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [KSZ_W-1:0] KSZ_RESET    = 3'd3;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

	typedef logic [PIX_W-1:0] pix_t;

	// Pipeline control toward the window unit
	typedef struct packed {
		logic load;   // a pixel transaction enters stage 1
		logic shift;  // stage 1 advances: update line store and window
	} win_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/bmf_window.sv
`default_nettype none

module bmf_window import bmf_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int KW         = $clog2(MAX_KERNEL + 1),
	parameter int CW         = $clog2(MAX_WIDTH),
	parameter int RSW        = $clog2(MAX_KERNEL * 255 + 1)
) (
	input  wire  logic                             clk,
	input  wire  logic                             arst_n,
	input  wire  win_ctl_t                         ctl,
	input  wire  logic [CW-1:0]                    addr,
	input  wire  pix_t                             pixel,
	input  wire  logic [KW-1:0]                    k,
	output logic       [MAX_KERNEL-1:0][RSW-1:0]   row_sum_s2
);

	localparam int LINES = MAX_KERNEL - 1;
	localparam int LW    = LINES * PIX_W;

	logic [LW-1:0]  mem [MAX_WIDTH];
	logic [LW-1:0]  rd_s1;
	logic [LW-1:0]  byp_s1;
	logic           byp_sel_s1;
	logic [CW-1:0]  addr_s1;
	pix_t           pix_s1;
	logic [LW-1:0]  lines;
	logic [LW-1:0]  new_lines;
	pix_t           col_pix [MAX_KERNEL];
	pix_t           win_q [MAX_KERNEL][MAX_KERNEL];
	pix_t           win_d [MAX_KERNEL][MAX_KERNEL];
	logic [MAX_KERNEL-1:0][RSW-1:0] row_sum_d;

	// Line store: read at accept, write back the pushed column when stage 1 advances
	always_ff @(posedge clk) begin
		if (ctl.shift)
			mem[addr_s1] <= new_lines;
		if (ctl.load)
			rd_s1 <= mem[addr];
	end

	// Capture the pixel, its column and a bypass copy of the column being written
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pix_s1  <= pixel;
			addr_s1 <= addr;
			byp_s1  <= new_lines;
		end
	end

	// Select bypass when the read raced the write to the same column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_sel_s1 <= 1'b0;
		end else if (ctl.load) begin
			byp_sel_s1 <= ctl.shift && (addr_s1 == addr);
		end
	end

	assign lines     = byp_sel_s1 ? byp_s1 : rd_s1;
	assign new_lines = {lines[LW-PIX_W-1:0], pix_s1};

	// Vertical column: current pixel, then the rows above it
	always_comb begin
		col_pix[0] = pix_s1;
		for (int j = 1; j < MAX_KERNEL; j++)
			col_pix[j] = lines[(j-1)*PIX_W +: PIX_W];
	end

	// Next window: shift one column, insert the new column
	always_comb begin
		for (int j = 0; j < MAX_KERNEL; j++) begin
			win_d[j][0] = col_pix[j];
			for (int i = 1; i < MAX_KERNEL; i++)
				win_d[j][i] = win_q[j][i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '{default: '0};
		end else if (ctl.shift) begin
			win_q <= win_d;
		end
	end

	// Row sums over the active k by k corner of the new window
	always_comb begin
		for (int j = 0; j < MAX_KERNEL; j++) begin
			row_sum_d[j] = '0;
			for (int i = 0; i < MAX_KERNEL; i++) begin
				if ((KW'(i) < k) && (KW'(j) < k))
					row_sum_d[j] = row_sum_d[j] + RSW'(win_d[j][i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift)
			row_sum_s2 <= row_sum_d;
	end

endmodule

`default_nettype wire

FILE: rtl/box_mean_filter_2d.sv
`default_nettype none

// Streaming k x k box mean filter for 8-bit grayscale pixels in raster order.
// One pixel is taken per clock while result_ready does not stall the pipeline,
// and each pixel yields exactly one result: the floor of the sum of the k x k
// window whose bottom-right corner is that pixel, divided by k*k (the filtered
// value of the window centre), with window_valid high only when the whole
// window lies inside the frame (mean_out is 0 otherwise) and frame_last marking
// the frame's final pixel. Each pixel passes in turn through the line store
// read, row sums, total and reciprocal multiply registers. The line store is a
// single memory with one read and one write port per clock, holding per column
// MAX_KERNEL-1 pixels, one per row above; it needs no clearing after reset.
// Write the window side, image width and image height registers over the
// register port only while the pipeline is empty.

module box_mean_filter_2d import bmf_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  wire  logic                  clk,
	input  wire  logic                  arst_n,
	// register port
	input  wire  logic                  psel,
	input  wire  logic                  penable,
	input  wire  logic                  pwrite,
	input  wire  logic [CFG_ADDR_W-1:0] paddr,
	input  wire  logic [CFG_DATA_W-1:0] pwdata,
	output logic       [CFG_DATA_W-1:0] prdata,
	output logic                        pready,
	// pixel channel
	input  wire  logic [PIX_W-1:0]      pixel_in,
	input  wire  logic                  pixel_valid,
	output logic                        pixel_ready,
	// result channel
	output logic       [PIX_W-1:0]      mean_out,
	output logic                        window_valid,
	output logic                        frame_last,
	output logic                        result_valid,
	input  wire  logic                  result_ready
);

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int RWC     = $clog2(MAX_HEIGHT);
	localparam int KW      = ($clog2(MAX_KERNEL + 1) > KSZ_W) ? $clog2(MAX_KERNEL + 1) : KSZ_W;
	localparam int KMAX    = (MAX_KERNEL % 2 == 1) ? MAX_KERNEL : MAX_KERNEL - 1;
	localparam int WDW     = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
	localparam int HDW     = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;
	localparam int RSW     = $clog2(MAX_KERNEL * 255 + 1);
	localparam int SUM_W   = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
	localparam int DW      = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int SHIFT   = SUM_W + DW;
	localparam int RECIP_W = SHIFT + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;

	typedef struct packed {
		logic valid;
		logic last;
	} res_flags_t;

	logic [KSZ_W-1:0] ksz_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             cfg_wr;
	logic [1:0]       cfg_idx;

	logic [KW-1:0]    k_raw;
	logic [KW-1:0]    k_eff;
	logic [WDW-1:0]   w_ext;
	logic [WDW-1:0]   w_eff;
	logic [HDW-1:0]   h_ext;
	logic [HDW-1:0]   h_eff;

	logic [CW-1:0]    col_q;
	logic [RWC-1:0]   row_q;
	logic             last_col;
	logic             last_row;
	res_flags_t       flags_in;

	logic             in_acc;
	logic             v_s1, v_s2, v_s3, v_s4;
	logic             free_s1, free_s2, free_s3, free_s4;
	logic             ld_s2, ld_s3, ld_s4;
	res_flags_t       flags_s1, flags_s2, flags_s3, flags_s4;

	win_ctl_t                       win_ctl;
	logic [MAX_KERNEL-1:0][RSW-1:0] row_sum_s2;
	logic [SUM_W-1:0]               total_d;
	logic [SUM_W-1:0]               total_s3;
	logic [RECIP_W-1:0]             recip_tab [2**KW];
	logic [PROD_W-1:0]              prod;
	logic [PIX_W-1:0]               mean_s4;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksz_q    <= KSZ_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_KERNEL: ksz_q    <= pwdata[KSZ_W-1:0];
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_KERNEL: prdata = CFG_DATA_W'(ksz_q);
			REG_WIDTH:  prdata = CFG_DATA_W'(width_q);
			REG_HEIGHT: prdata = CFG_DATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Effective kernel side: force odd, limit to the largest odd size built
	assign k_raw = KW'(ksz_q | KSZ_W'(1));
	assign k_eff = (k_raw > KW'(KMAX)) ? KW'(KMAX) : k_raw;

	// Effective frame size: zero reads as one, saturate at the maximum
	assign w_ext = WDW'(width_q);
	assign h_ext = HDW'(height_q);
	assign w_eff = (w_ext == '0) ? WDW'(1) : ((w_ext > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : w_ext);
	assign h_eff = (h_ext == '0) ? HDW'(1)
		: ((h_ext > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : h_ext);

	assign last_col       = WDW'(col_q) >= (w_eff - WDW'(1));
	assign last_row       = HDW'(row_q) >= (h_eff - HDW'(1));
	assign flags_in.valid = (row_q >= RWC'(k_eff - KW'(1))) && (col_q >= CW'(k_eff - KW'(1)));
	assign flags_in.last  = last_col && last_row;

	// Pipeline handshake: each stage loads when the next one frees up
	assign free_s4     = !v_s4 || result_ready;
	assign ld_s4       = v_s3 && free_s4;
	assign free_s3     = !v_s3 || free_s4;
	assign ld_s3       = v_s2 && free_s3;
	assign free_s2     = !v_s2 || free_s3;
	assign ld_s2       = v_s1 && free_s2;
	assign free_s1     = !v_s1 || free_s2;
	assign pixel_ready = free_s1;
	assign in_acc      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_acc || (v_s1 && !ld_s2);
			v_s2 <= ld_s2  || (v_s2 && !ld_s3);
			v_s3 <= ld_s3  || (v_s3 && !ld_s4);
			v_s4 <= ld_s4  || (v_s4 && !result_ready);
		end
	end

	// Advance the raster position on every accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RWC'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Line store, window and row sums
	assign win_ctl.load  = in_acc;
	assign win_ctl.shift = ld_s2;

	bmf_window #(
		.MAX_KERNEL (MAX_KERNEL),
		.MAX_WIDTH  (MAX_WIDTH),
		.KW         (KW),
		.CW         (CW),
		.RSW        (RSW)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (win_ctl),
		.addr       (col_q),
		.pixel      (pixel_in),
		.k          (k_eff),
		.row_sum_s2 (row_sum_s2)
	);

	// Reciprocal of k*k, rounded up, exact for every window sum
	for (genvar g = 0; g < 2**KW; g++) begin : g_recip
		localparam longint unsigned D = (g == 0) ? 1 : g * g;
		localparam longint unsigned R = ((64'd1 << SHIFT) + D - 1) / D;
		assign recip_tab[g] = RECIP_W'(R);
	end

	// Add the row sums
	always_comb begin
		total_d = '0;
		for (int j = 0; j < MAX_KERNEL; j++)
			total_d = total_d + SUM_W'(row_sum_s2[j]);
	end

	assign prod = PROD_W'(total_s3) * PROD_W'(recip_tab[k_eff]);

	// Carry flags and sums down the stages
	always_ff @(posedge clk) begin
		if (in_acc)
			flags_s1 <= flags_in;
		if (ld_s2)
			flags_s2 <= flags_s1;
		if (ld_s3) begin
			flags_s3 <= flags_s2;
			total_s3 <= total_d;
		end
		if (ld_s4) begin
			flags_s4 <= flags_s3;
			mean_s4  <= flags_s3.valid ? prod[SHIFT +: PIX_W] : '0;
		end
	end

	assign result_valid = v_s4;
	assign mean_out     = mean_s4;
	assign window_valid = flags_s4.valid;
	assign frame_last   = flags_s4.last;

	// A full pipeline with a stalled result blocks new pixels
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !result_ready) |-> !pixel_ready)
		else $error("pixel accepted into a full stalled pipeline");

	// Invalid windows carry a zero mean
	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !window_valid) |-> (mean_out == '0))
		else $error("nonzero mean on an invalid window");

	// The last pixel of a frame restarts the raster position
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && flags_in.last) |=> (col_q == '0) && (row_q == '0))
		else $error("raster position did not wrap after the frame's last pixel");

	// Position stays within the line store and frame limits
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < MAX_WIDTH) && (int'(row_q) < MAX_HEIGHT))
		else $error("raster position out of range");

endmodule

`default_nettype wire
